// File: rtl/spbb_pkg.sv
// spbb_pkg: shared types, constants and the saturation helper for the swept
// box builder. No dependencies; every other file of the block imports it.
package spbb_pkg;

  localparam int COORD_W    = 32;
  localparam int GAP_W      = 31;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 12;
  localparam int MODE_W     = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_AXES   = 3;
  // (end - start) is 33 bits signed, scale is 16 bits unsigned
  localparam int PROD_W     = COORD_W + 1 + SCALE_W;
  localparam int SUM_W      = PROD_W - SCALE_FRAC + 1;
  localparam int MARGIN_W   = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef enum logic [MODE_W-1:0] {
    MM_HALF_GAP = 2'd0,
    MM_OFFSET   = 2'd1,
    MM_NONE     = 2'd2
  } margin_mode_t;

  typedef enum logic [0:0] {
    CFG_SCALE = 1'b0,
    CFG_MODE  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    coord_t             start_x;
    coord_t             start_y;
    coord_t             start_z;
    coord_t             end_x;
    coord_t             end_y;
    coord_t             end_z;
    logic [GAP_W-1:0]   gap_width;
    logic [GAP_W-1:0]   contact_offset;
    logic               mask_active;
    logic               last_vertex;
  } vtx_t;

  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
    logic   box_active;
  } box_t;

  // stage moves decided by the top level
  typedef struct packed {
    logic load2;
    logic take2;
    logic take3;
  } pipe_ctl_t;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] hi_bits;
    hi_bits = v[SUM_W-1:COORD_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

endpackage

// File: rtl/spbb_if.sv
// spbb_vtx_if and spbb_box_if: valid/ready channels of the swept box builder.
// Depends on spbb_pkg for the vertex and box payload types.
interface spbb_vtx_if import spbb_pkg::*; ();
  logic valid;
  logic ready;
  vtx_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface spbb_box_if import spbb_pkg::*; ();
  logic valid;
  logic ready;
  box_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/spbb_sweep.sv
// spbb_sweep: product stage; (end - start) * scale per axis and the margin.
// Depends on spbb_pkg.
module spbb_sweep import spbb_pkg::*; #(
  parameter int AXES = 3
) (
  input  logic                     clk,
  input  pipe_ctl_t                ctl,
  input  vtx_t                     vtx,
  input  logic [SCALE_W-1:0]       scale,
  input  logic [MODE_W-1:0]        mode,
  output coord_t                   start_r [AXES],
  output logic signed [PROD_W-1:0] prod_r [AXES],
  output logic [MARGIN_W-1:0]      margin_r,
  output logic                     mask_r,
  output logic                     last_r
);

  coord_t               st [MAX_AXES];
  coord_t               en [MAX_AXES];
  logic [MARGIN_W-1:0]  margin_nxt;

  assign st[0] = vtx.start_x;
  assign st[1] = vtx.start_y;
  assign st[2] = vtx.start_z;
  assign en[0] = vtx.end_x;
  assign en[1] = vtx.end_y;
  assign en[2] = vtx.end_z;

  always_comb begin
    unique case (mode)
      MM_HALF_GAP: margin_nxt = MARGIN_W'(vtx.gap_width[GAP_W-1:1])
                                + MARGIN_W'(vtx.contact_offset);
      MM_OFFSET:   margin_nxt = MARGIN_W'(vtx.contact_offset);
      default:     margin_nxt = '0;
    endcase
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic signed [COORD_W:0]   diff;
    logic signed [PROD_W-1:0]  prod_nxt;

    assign diff     = {en[a][COORD_W-1], en[a]} - {st[a][COORD_W-1], st[a]};
    assign prod_nxt = PROD_W'(diff) * PROD_W'($signed({1'b0, scale}));

    always_ff @(posedge clk) begin
      if (ctl.load2) begin
        start_r[a] <= st[a];
        prod_r[a]  <= prod_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      margin_r <= margin_nxt;
      mask_r   <= vtx.mask_active;
      last_r   <= vtx.last_vertex;
    end
  end

endmodule

// File: rtl/spbb_bound.sv
// spbb_bound: extrapolated point, per-axis running min/max over a primitive,
// and the held bounds of a finished primitive. Depends on spbb_pkg.
module spbb_bound import spbb_pkg::*; #(
  parameter int AXES = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pipe_ctl_t                ctl,
  input  coord_t                   s2_start [AXES],
  input  logic signed [PROD_W-1:0] s2_prod [AXES],
  input  logic [MARGIN_W-1:0]      s2_margin,
  input  logic                     s2_mask,
  input  logic                     s2_last,
  output coord_t                   bnd_lo_r [AXES],
  output coord_t                   bnd_hi_r [AXES],
  output logic [MARGIN_W-1:0]      bnd_margin_r,
  output logic                     bnd_mask_r
);

  logic prim_start_r;
  logic load3;

  assign load3 = ctl.take2 && s2_last;

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic signed [SUM_W-COORD_W-1+COORD_W-1:0] q;
    logic signed [SUM_W-1:0]  sum;
    coord_t                   z;
    coord_t                   lo;
    coord_t                   hi;
    coord_t                   lo_nxt;
    coord_t                   hi_nxt;
    coord_t                   run_lo_r;
    coord_t                   run_hi_r;

    // arithmetic shift is the floor divide by 2^SCALE_FRAC
    assign q   = $signed(s2_prod[a][PROD_W-1:SCALE_FRAC]);
    assign sum = SUM_W'(s2_start[a]) + SUM_W'(q);
    assign z   = sat_coord(sum);
    assign lo  = (s2_start[a] < z) ? s2_start[a] : z;
    assign hi  = (s2_start[a] > z) ? s2_start[a] : z;

    assign lo_nxt = (prim_start_r || lo < run_lo_r) ? lo : run_lo_r;
    assign hi_nxt = (prim_start_r || hi > run_hi_r) ? hi : run_hi_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        run_lo_r <= '0;
        run_hi_r <= '0;
      end else if (ctl.take2) begin
        run_lo_r <= lo_nxt;
        run_hi_r <= hi_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (load3) begin
        bnd_lo_r[a] <= lo_nxt;
        bnd_hi_r[a] <= hi_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prim_start_r <= 1'b1;
    end else if (ctl.take2) begin
      prim_start_r <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      bnd_margin_r <= s2_margin;
      bnd_mask_r   <= s2_mask;
    end
  end

endmodule

// File: rtl/spbb_margin.sv
// spbb_margin: result register; widens the held bounds by the margin with
// saturation. Depends on spbb_pkg.
module spbb_margin import spbb_pkg::*; #(
  parameter int AXES = 3
) (
  input  logic                clk,
  input  pipe_ctl_t           ctl,
  input  coord_t              bnd_lo [AXES],
  input  coord_t              bnd_hi [AXES],
  input  logic [MARGIN_W-1:0] margin,
  input  logic                mask,
  output box_t                box_r
);

  coord_t lo_v [MAX_AXES];
  coord_t hi_v [MAX_AXES];
  logic signed [SUM_W-1:0] margin_ext;

  assign margin_ext = SUM_W'($signed({1'b0, margin}));

  for (genvar a = 0; a < MAX_AXES; a++) begin : g_axis
    if (a < AXES) begin : g_used
      assign lo_v[a] = sat_coord(SUM_W'(bnd_lo[a]) - margin_ext);
      assign hi_v[a] = sat_coord(SUM_W'(bnd_hi[a]) + margin_ext);
    end else begin : g_unused
      assign lo_v[a] = '0;
      assign hi_v[a] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take3) begin
      box_r.box_min_x  <= lo_v[0];
      box_r.box_min_y  <= lo_v[1];
      box_r.box_min_z  <= lo_v[2];
      box_r.box_max_x  <= hi_v[0];
      box_r.box_max_y  <= hi_v[1];
      box_r.box_max_z  <= hi_v[2];
      box_r.box_active <= mask;
    end
  end

endmodule

// File: rtl/swept_primitive_box_builder.sv
// Swept box builder: one vertex request per cycle in unless stalled, one box per primitive out.
// Depends on spbb_pkg, spbb_if, spbb_sweep, spbb_bound and spbb_margin.
//
// Takes one vertex request every clock cycle unless back-pressure stalls it.
// A vertex passes an input register, a product stage (one 33x17 multiplier
// per axis), the bound stage that folds it into the running per-axis min/max,
// and for the last vertex of a primitive the result register that adds the
// margin and holds the box. One finished box can be held in the bound stage
// and one in the result register while later vertices keep flowing; a vertex
// request is refused only when a third box would pile up behind an output
// that is not taken. Write extrapolate_scale (index 0) and margin_mode
// (index 1) only while no request is in flight.
module swept_primitive_box_builder import spbb_pkg::*; #(
  parameter int AXES = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  spbb_vtx_if.sink              in_vtx,
  spbb_box_if.source            out_box,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SCALE_W-1:0]       scale_r;
  logic [MODE_W-1:0]        mode_r;

  vtx_t                     s1_r;
  logic                     v1_r;
  logic                     v2_r;
  logic                     v3_r;
  logic                     out_valid_r;

  coord_t                   s2_start [AXES];
  logic signed [PROD_W-1:0] s2_prod [AXES];
  logic [MARGIN_W-1:0]      s2_margin;
  logic                     s2_mask;
  logic                     s2_last;

  coord_t                   bnd_lo [AXES];
  coord_t                   bnd_hi [AXES];
  logic [MARGIN_W-1:0]      bnd_margin;
  logic                     bnd_mask;
  box_t                     box;

  pipe_ctl_t                ctl;
  logic                     free2;
  logic                     free3;
  logic                     accept;

  // a stage moves when the one after it is empty or moving;
  // non-last vertices never need the result side
  assign ctl.take3     = v3_r && (!out_valid_r || out_box.ready);
  assign free3         = !v3_r || ctl.take3;
  assign ctl.take2     = v2_r && (!s2_last || free3);
  assign free2         = !v2_r || ctl.take2;
  assign ctl.load2     = v1_r && free2;
  assign in_vtx.ready  = !v1_r || ctl.load2;
  assign accept        = in_vtx.valid && in_vtx.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_W'(4096);
      mode_r  <= MM_HALF_GAP;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SCALE: scale_r <= cfg_data[SCALE_W-1:0];
        CFG_MODE:  mode_r  <= cfg_data[MODE_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept || (v1_r && !ctl.load2);
      v2_r        <= ctl.load2 || (v2_r && !ctl.take2);
      v3_r        <= (ctl.take2 && s2_last) || (v3_r && !ctl.take3);
      out_valid_r <= ctl.take3 || (out_valid_r && !out_box.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_vtx.data;
    end
  end

  spbb_sweep #(.AXES(AXES)) u_sweep (
    .clk      (clk),
    .ctl      (ctl),
    .vtx      (s1_r),
    .scale    (scale_r),
    .mode     (mode_r),
    .start_r  (s2_start),
    .prod_r   (s2_prod),
    .margin_r (s2_margin),
    .mask_r   (s2_mask),
    .last_r   (s2_last)
  );

  spbb_bound #(.AXES(AXES)) u_bound (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .s2_start     (s2_start),
    .s2_prod      (s2_prod),
    .s2_margin    (s2_margin),
    .s2_mask      (s2_mask),
    .s2_last      (s2_last),
    .bnd_lo_r     (bnd_lo),
    .bnd_hi_r     (bnd_hi),
    .bnd_margin_r (bnd_margin),
    .bnd_mask_r   (bnd_mask)
  );

  spbb_margin #(.AXES(AXES)) u_margin (
    .clk    (clk),
    .ctl    (ctl),
    .bnd_lo (bnd_lo),
    .bnd_hi (bnd_hi),
    .margin (bnd_margin),
    .mask   (bnd_mask),
    .box_r  (box)
  );

  assign out_box.valid = out_valid_r;
  assign out_box.data  = box;

endmodule
